// ===== design/frame_delta_mask_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder assertion macros
// Shorthand for the concurrent checks used inside the encoder back end.
// ----------------------------------------------------------------------------
`ifndef FRAME_DELTA_MASK_ENCODER_MACROS_SVH
`define FRAME_DELTA_MASK_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fdme_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder package
// Shared types and constants for the front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package fdme_pkg;

    localparam int MAX_TILES_DEF = 64;
    localparam int MAX_MASKS_DEF = 64;

    localparam int CFG_W      = 7;
    localparam int TILE_W     = 8;
    localparam int MASK_W     = 64;
    localparam int NBYTES_W   = 4;
    localparam int CFG_RESET  = 49;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TILE  = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_BYTE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              restart;
    } t_req;

    typedef struct packed {
        t_kind             kind;
        logic [TILE_W-1:0] value;
        logic              mask_is_new;
        logic              table_full;
        logic              last;
    } t_res;

    // Work handed from the front end to the back end for one tile.
    typedef struct packed {
        logic                clr;
        logic                changed;
        logic                search;
        logic [TILE_W-1:0]   tile;
        logic [MASK_W-1:0]   mask;
        logic [NBYTES_W-1:0] nbytes;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/fdme_front.sv =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder front end
// Accepts tiles, keeps the base frame and the change mask, and classifies
// each tile into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fdme_front import fdme_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  t_req              i_req,
    output logic              full,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              cfg_ready,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [CFG_W-1:0] MAXT = CFG_W'(MAX_TILES);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [CFG_W-1:0]    r_pos;
    logic                r_loading;
    logic [MASK_W-1:0]   r_mask;
    logic [TILE_W-1:0]   r_tile;
    logic [TILE_W-1:0]   r_base;
    logic [CFG_W-1:0]    r_cur_pos;
    logic                r_cur_load;
    logic                r_cur_eof;
    logic                r_cur_clr;
    logic [NBYTES_W-1:0] r_nbytes;
    logic [TILE_W-1:0]   r_frame [MAX_TILES];

    logic [CFG_W-1:0]    ft;
    logic [CFG_W-1:0]    ft_plus;
    logic                accept;
    logic                clear0;
    logic [CFG_W-1:0]    pos0;
    logic                load0;
    logic                eof0;
    logic                changed;
    logic                search;
    logic [MASK_W-1:0]   mask1;

    assign cfg_ready = 1'b1;
    assign full      = (r_state != S_IDLE) || i_q_full;
    assign accept    = push && !full;

    always_comb begin
        if (r_cfg == '0) begin
            ft = CFG_W'(1);
        end else if (r_cfg > MAXT) begin
            ft = MAXT;
        end else begin
            ft = r_cfg;
        end
    end

    assign ft_plus = ft + CFG_W'(7);
    assign clear0  = i_req.restart || (r_pos >= ft);
    assign pos0    = clear0 ? '0 : r_pos;
    assign load0   = i_req.restart || r_loading;
    assign eof0    = (CFG_W'(pos0 + CFG_W'(1)) >= ft);

    assign changed = !r_cur_load && (r_tile != r_base);
    assign search  = !r_cur_load && r_cur_eof;
    assign mask1   = r_mask | (changed ? (MASK_W'(1) << r_cur_pos) : '0);

    assign o_q_push        = (r_state == S_CMP) && (changed || search || r_cur_clr);
    assign o_q_cmd.clr     = r_cur_clr;
    assign o_q_cmd.changed = changed;
    assign o_q_cmd.search  = search;
    assign o_q_cmd.tile    = r_tile;
    assign o_q_cmd.mask    = mask1;
    assign o_q_cmd.nbytes  = r_nbytes;

    // Base frame store: written while loading, read for the compare.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (load0) begin
                r_frame[pos0[AW-1:0]] <= i_req.tile;
            end
            r_base <= r_frame[pos0[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_W'(CFG_RESET);
            r_pos     <= '0;
            r_loading <= 1'b1;
            r_mask    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tile     <= i_req.tile;
                        r_cur_pos  <= pos0;
                        r_cur_load <= load0;
                        r_cur_eof  <= eof0;
                        r_cur_clr  <= i_req.restart;
                        r_nbytes   <= ft_plus[CFG_W-1:3];
                        r_pos      <= eof0 ? '0 : CFG_W'(pos0 + CFG_W'(1));
                        r_mask     <= clear0 ? '0 : r_mask;
                        if (load0) begin
                            r_loading <= !eof0;
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_mask  <= search ? '0 : mask1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/fdme_queue.sv =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fdme_queue import fdme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/fdme_back.sv =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder back end
// Emits changed tiles, searches the mask table at the end of each frame and
// emits the mask index and, for a new mask, its bytes, or a table-full result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_delta_mask_encoder_macros.svh"

module fdme_back import fdme_pkg::*; #(
    parameter int MAX_MASKS = MAX_MASKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic empty,
    input  logic pop
);

    localparam int CW = $clog2(MAX_MASKS + 1);
    localparam int AW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MASKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TILE,
        S_SEARCH,
        S_INDEX,
        S_BYTES
    } t_state;

    t_state              r_state;
    logic [MASK_W-1:0]   r_table [MAX_MASKS];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_ridx;
    logic [CW-1:0]       r_cidx;
    logic [CW-1:0]       r_hit;
    logic                r_pend;
    logic                r_found;
    logic [MASK_W-1:0]   r_rd;
    logic [MASK_W-1:0]   r_mask;
    logic [TILE_W-1:0]   r_tile;
    logic                r_search;
    logic [NBYTES_W-1:0] r_nbytes;
    logic [NBYTES_W-1:0] r_left;
    t_res                r_res;
    logic                r_ovalid;

    logic          pop_ok;
    logic          slot_free;
    logic          res_load;
    logic          hit;
    logic          all_issued;
    logic          do_read;
    logic          do_write;
    logic [CW-1:0] cnt_inc;
    logic          full_res;
    logic          full_ok;
    logic          new_res;
    logic          new_ok;

    assign pop_ok     = pop && r_ovalid;
    assign slot_free  = !r_ovalid || pop_ok;
    assign res_load   = slot_free && (r_state inside {S_TILE, S_INDEX, S_BYTES});
    assign hit        = r_pend && (r_rd == r_mask);
    assign all_issued = (r_ridx == r_count);
    assign do_read    = (r_state == S_SEARCH) && !hit && !all_issued;
    assign do_write   = (r_state == S_INDEX) && slot_free && !r_found && (r_count < MAX_CNT);
    assign cnt_inc    = CW'(r_count + 1'b1);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res      = r_res;
    assign empty      = !r_ovalid;

    assign full_res = r_ovalid && r_res.table_full;
    assign full_ok  = r_res.last && !r_res.mask_is_new && (r_res.kind == KIND_INDEX);
    assign new_res  = r_ovalid && r_res.mask_is_new;
    assign new_ok   = !r_res.last && (r_state == S_BYTES);

    // Mask table: one write and one read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_table[r_count[AW-1:0]] <= r_mask;
        end
        if (do_read) begin
            r_rd <= r_table[r_ridx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (pop_ok && !res_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.clr) begin
                            r_count <= '0;
                        end
                        r_tile   <= i_cmd.tile;
                        r_mask   <= i_cmd.mask;
                        r_search <= i_cmd.search;
                        r_nbytes <= i_cmd.nbytes;
                        r_ridx   <= '0;
                        r_pend   <= 1'b0;
                        if (i_cmd.changed) begin
                            r_state <= S_TILE;
                        end else if (i_cmd.search) begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_TILE: begin
                    if (slot_free) begin
                        r_res.kind        <= KIND_TILE;
                        r_res.value       <= r_tile;
                        r_res.mask_is_new <= 1'b0;
                        r_res.table_full  <= 1'b0;
                        r_res.last        <= !r_search;
                        r_ovalid          <= 1'b1;
                        r_state           <= r_search ? S_SEARCH : S_IDLE;
                    end
                end
                S_SEARCH: begin
                    // One table read per cycle; the compare uses registered r_rd.
                    if (hit) begin
                        r_found <= 1'b1;
                        r_hit   <= r_cidx;
                        r_state <= S_INDEX;
                    end else if (all_issued) begin
                        r_found <= 1'b0;
                        r_state <= S_INDEX;
                    end else begin
                        r_cidx <= r_ridx;
                        r_ridx <= CW'(r_ridx + 1'b1);
                        r_pend <= 1'b1;
                    end
                end
                S_INDEX: begin
                    if (slot_free) begin
                        r_res.kind <= KIND_INDEX;
                        r_ovalid   <= 1'b1;
                        if (r_found) begin
                            r_res.value       <= TILE_W'(r_hit);
                            r_res.mask_is_new <= 1'b0;
                            r_res.table_full  <= 1'b0;
                            r_res.last        <= 1'b1;
                            r_state           <= S_IDLE;
                        end else if (r_count < MAX_CNT) begin
                            r_res.value       <= TILE_W'(r_count);
                            r_res.mask_is_new <= 1'b1;
                            r_res.table_full  <= 1'b0;
                            r_res.last        <= 1'b0;
                            r_count           <= cnt_inc;
                            r_left            <= r_nbytes;
                            r_state           <= S_BYTES;
                        end else begin
                            r_res.value       <= '0;
                            r_res.mask_is_new <= 1'b0;
                            r_res.table_full  <= 1'b1;
                            r_res.last        <= 1'b1;
                            r_state           <= S_IDLE;
                        end
                    end
                end
                S_BYTES: begin
                    if (slot_free) begin
                        r_res.kind        <= KIND_BYTE;
                        r_res.value       <= r_mask[TILE_W-1:0];
                        r_res.mask_is_new <= 1'b0;
                        r_res.table_full  <= 1'b0;
                        r_res.last        <= (r_left == NBYTES_W'(1));
                        r_ovalid          <= 1'b1;
                        r_mask            <= r_mask >> TILE_W;
                        r_left            <= NBYTES_W'(r_left - 1'b1);
                        if (r_left == NBYTES_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FDME_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT, "mask count too high")
    `FDME_ASSERT_NOW(a_full_alone, i_clk, i_rst_n, full_res, full_ok, "malformed table full result")
    `FDME_ASSERT_NOW(a_new_has_bytes, i_clk, i_rst_n, new_res, new_ok, "new index without bytes")
    `FDME_ASSERT_NEXT(a_write_inc, i_clk, i_rst_n, do_write, r_count == $past(cnt_inc), "count not stepped")

endmodule

`default_nettype wire

// ===== design/frame_delta_mask_encoder.sv =====
// ----------------------------------------------------------------------------
// Frame delta mask encoder
// Stores a base tilemap frame, emits the tiles of later frames that differ
// from it, and encodes each frame's change mask through a table of masks.
//
//   channel   direction  handshake            payload
//   request   in         push / full          i_req  (tile, restart)
//   result    out        empty / pop          o_res  (kind, value, flags, last)
//   config    in         cfg_valid/cfg_ready  i_cfg_data (frame_tiles)
//
// The front end takes a tile, then holds full through its compare state before the next,
// limited by the registered base frame read. The back end handles commands and results
// one at a time, plus a table search at each frame end, one mask table read per cycle.
// full is high during each compare cycle and while the two-entry command queue is full,
// which happens while the back end searches or waits on pop and commands keep coming.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_delta_mask_encoder import fdme_pkg::*; #(
    parameter int MAX_TILES = MAX_TILES_DEF,
    parameter int MAX_MASKS = MAX_MASKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  t_req             i_req,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output t_res             o_res,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             cfg_ready
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    logic q_pop;
    t_cmd q_out;

    fdme_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_req      (i_req),
        .full       (full),
        .cfg_valid  (cfg_valid),
        .i_cfg_data (i_cfg_data),
        .cfg_ready  (cfg_ready),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    fdme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    fdme_back #(
        .MAX_MASKS (MAX_MASKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_res       (o_res),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire

// ===== tb/frame_delta_mask_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame delta mask encoder testbench
// Pushes tilemap frames into the encoder under several frame sizes, with
// random idling on both queues, and checks every popped result in order against a
// behavioral model of base frames, change masks and the mask table, or a written-in result.
// ----------------------------------------------------------------------------

module frame_delta_mask_encoder_test;
    import fdme_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 20;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int N_DIRECTED   = 23;
    localparam int MASK_FRAMES  = 6;
    localparam int MAX_SHOWN    = 60;

    localparam t_res NO_RES    = '{KIND_TILE, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam t_res TILE_FF   = '{KIND_TILE, 8'hFF, 1'b0, 1'b0, 1'b1};
    localparam t_res TILE_00   = '{KIND_TILE, 8'h00, 1'b0, 1'b0, 1'b1};
    localparam t_res MATCH_IX0 = '{KIND_INDEX, 8'h00, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              restart;
        logic              typed;
        logic              has_res;
        t_res              res;
    } t_dir_row;

    // Directed rows run with four tiles per frame. Rows with typed cleared
    // are checked against the model instead of a written-in result.
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // Base frame 00 FF 00 FF, starting with a restart.
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
        // Unchanged frame: the empty mask becomes entry 0.
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        // Every tile changed: a new full mask.
        '{8'hFF, 1'b0, 1'b1, 1'b1, TILE_FF},
        '{8'h00, 1'b0, 1'b1, 1'b1, TILE_00},
        '{8'hFF, 1'b0, 1'b1, 1'b1, TILE_FF},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        // Same changes again: the mask is found in the table.
        '{8'hFF, 1'b0, 1'b1, 1'b1, TILE_FF},
        '{8'h00, 1'b0, 1'b1, 1'b1, TILE_00},
        '{8'hFF, 1'b0, 1'b1, 1'b1, TILE_FF},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        // Unchanged again: matches entry 0.
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b1, MATCH_IX0},
        // A restart in the middle of a frame.
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h5A, 1'b1, 1'b1, 1'b0, NO_RES}
    };

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             push       = 1'b0;
    t_req             i_req      = '0;
    logic             pop        = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             full;
    logic             empty;
    logic             cfg_ready;
    t_res             o_res;

    frame_delta_mask_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_req      (i_req),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .cfg_valid  (cfg_valid),
        .i_cfg_data (i_cfg_data),
        .cfg_ready  (cfg_ready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Model state.
    logic [CFG_W-1:0]  ft_reg;
    logic [TILE_W-1:0] base_tiles [MAX_TILES_DEF];
    bit                base_written [MAX_TILES_DEF];
    logic [6:0]        pos_m;
    bit                loading_m;
    logic [MASK_W-1:0] cmask_m;
    logic [MASK_W-1:0] mask_tab [MAX_MASKS_DEF];
    int                mask_cnt;

    t_res step_results [$];
    t_res pending_results [$];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  cfg_writes;
    int  stall_cycles;
    int  masks_added;
    int  masks_matched;
    int  table_full_hits;
    bit  send_steady;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    function automatic int frame_len();
        int ft;
        ft = ft_reg;
        if (ft < 1) ft = 1;
        if (ft > MAX_TILES_DEF) ft = MAX_TILES_DEF;
        return ft;
    endfunction

    function automatic void clear_tilemap();
        foreach (base_tiles[i]) begin
            base_tiles[i]   = '0;
            base_written[i] = 1'b0;
        end
        foreach (mask_tab[i]) mask_tab[i] = '0;
        pos_m     = '0;
        loading_m = 1'b1;
        cmask_m   = '0;
        mask_cnt  = 0;
    endfunction

    function automatic void add_result(input t_kind k, input logic [7:0] v,
                                       input logic nw, input logic fl);
        t_res res;
        res.kind        = k;
        res.value       = v;
        res.mask_is_new = nw;
        res.table_full  = fl;
        res.last        = 1'b0;
        step_results.push_back(res);
    endfunction

    // Works out the results of one accepted tile request into step_results.
    function automatic void encode_tile(input t_req r);
        int   ft;
        int   p;
        int   idx;
        int   nbytes;
        bit   found;
        t_res tail;
        step_results.delete();
        ft = frame_len();
        if (r.restart) clear_tilemap();
        if (pos_m >= ft) begin
            pos_m   = '0;
            cmask_m = '0;
        end
        p = pos_m;
        if (loading_m) begin
            base_tiles[p]   = r.tile;
            base_written[p] = 1'b1;
            if (p + 1 >= ft) begin
                loading_m = 1'b0;
                pos_m     = '0;
            end else begin
                pos_m = 7'(p + 1);
            end
            return;
        end
        if (r.tile != base_tiles[p]) begin
            cmask_m[p] = 1'b1;
            add_result(KIND_TILE, r.tile, 1'b0, 1'b0);
        end
        if (p + 1 >= ft) begin
            found = 1'b0;
            idx   = 0;
            for (int i = 0; i < mask_cnt; i++) begin
                if (!found && mask_tab[i] == cmask_m) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found) begin
                add_result(KIND_INDEX, 8'(idx), 1'b0, 1'b0);
                masks_matched++;
            end else if (mask_cnt < MAX_MASKS_DEF) begin
                mask_tab[mask_cnt] = cmask_m;
                add_result(KIND_INDEX, 8'(mask_cnt), 1'b1, 1'b0);
                mask_cnt++;
                masks_added++;
                nbytes = (ft + 7) / 8;
                for (int k = 0; k < nbytes; k++)
                    add_result(KIND_BYTE, cmask_m[8*k +: 8], 1'b0, 1'b0);
            end else begin
                add_result(KIND_INDEX, 8'h00, 1'b0, 1'b1);
                table_full_hits++;
            end
            cmask_m = '0;
            pos_m   = '0;
        end else begin
            pos_m = 7'(p + 1);
        end
        if (step_results.size() > 0) begin
            tail      = step_results[step_results.size()-1];
            tail.last = 1'b1;
            step_results[step_results.size()-1] = tail;
        end
    endfunction

    // Picks the next tile; a restart is forced whenever the next compare would
    // read a base position that was never loaded.
    function automatic t_req pick_tile(input int change_pct, input int restart_pct);
        t_req r;
        int   ft;
        int   p;
        ft = frame_len();
        p  = (pos_m >= ft) ? 0 : int'(pos_m);
        r.restart = ($urandom_range(0, 99) < restart_pct) ||
                    (!loading_m && !base_written[p]);
        r.tile = 8'($urandom_range(0, 255));
        if (!r.restart && !loading_m) begin
            if ($urandom_range(0, 99) < change_pct)
                r.tile = base_tiles[p] ^ 8'($urandom_range(1, 255));
            else
                r.tile = base_tiles[p];
        end
        return r;
    endfunction

    task automatic send_tile(input t_req r, input bit typed = 1'b0,
                             input bit has_res = 1'b0, input t_res typed_res = NO_RES);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        items_sent++;
        encode_tile(r);
        if (!typed) begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end else if (has_res) begin
            pending_results.push_back(typed_res);
        end
    endtask

    // The register only changes while the encoder has nothing in flight.
    task automatic write_frame_tiles(input logic [CFG_W-1:0] v);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid  <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        ft_reg = v;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] ft, input int count,
                             input int change_pct, input int restart_pct);
        write_frame_tiles(ft);
        repeat (count) send_tile(pick_tile(change_pct, restart_pct));
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        results_checked++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected: kind %0d value %02h",
                                      got.kind, got.value));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                      results_checked, got.kind, want.kind));
        if (got.value !== want.value)
            report_mismatch($sformatf("result %0d: value %02h, expected %02h",
                                      results_checked, got.value, want.value));
        if (got.mask_is_new !== want.mask_is_new)
            report_mismatch($sformatf("result %0d: mask_is_new %0b, expected %0b",
                                      results_checked, got.mask_is_new, want.mask_is_new));
        if (got.table_full !== want.table_full)
            report_mismatch($sformatf("result %0d: table_full %0b, expected %0b",
                                      results_checked, got.table_full, want.table_full));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                      results_checked, got.last, want.last));
    endtask

    initial begin : result_sink
        int gap;
        bit steady;
        bit held;
        steady = 1'b0;
        held   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 7);
            // One long hold-off while the mask frames stream in, so that the
            // encoder backs up into the request side.
            if (!held && results_checked == HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_result(o_res);
        end
    end

    initial begin : stimulus
        t_req r;
        ft_reg      = 7'(CFG_RESET);
        send_steady = 1'b0;
        clear_tilemap();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_frame_tiles(7'd4);
        for (int k = 0; k < N_DIRECTED; k++) begin
            r.tile    = DIRECTED[k].tile;
            r.restart = DIRECTED[k].restart;
            send_tile(r, DIRECTED[k].typed, DIRECTED[k].has_res, DIRECTED[k].res);
        end

        // Seven-tile frames whose masks count up, then a frame that hits an
        // existing entry and one that adds the empty mask.
        write_frame_tiles(7'd7);
        r = pick_tile(0, 0);
        r.restart = 1'b1;
        send_tile(r);
        repeat (6) send_tile(pick_tile(0, 0));
        for (int f = 1; f <= MASK_FRAMES; f++) begin
            for (int j = 0; j < 7; j++)
                send_tile(pick_tile(f[j] ? 100 : 0, 0));
        end
        for (int j = 0; j < 7; j++) send_tile(pick_tile(j == 0 ? 100 : 0, 0));
        for (int j = 0; j < 7; j++) send_tile(pick_tile(0, 0));

        run_phase(7'd127, 136, 20, 0);
        run_phase(7'd0, 10, 50, 3);
        run_phase(7'd1, 8, 50, 3);
        run_phase(7'd9, 20, 15, 3);
        run_phase(7'd3, 12, 30, 3);
        run_phase(7'($urandom_range(2, 16)), 15, 25, 3);

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Run covered %0d tile requests and %0d results across %0d frame sizes.",
                 items_sent, results_checked, cfg_writes);
        $display("Masks: %0d added, %0d matched, %0d refused on a full table; %0d stall cycles.",
                 masks_added, masks_matched, table_full_hits, stall_cycles);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timeout after %0d ns.", RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
